### hdl/json_token_structure_checker_unit_defines.svh
// assertion macros shared by the json token checker rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef JSON_TOKEN_STRUCTURE_CHECKER_UNIT_DEFINES_SVH
`define JSON_TOKEN_STRUCTURE_CHECKER_UNIT_DEFINES_SVH

// check on every clock edge outside reset
`define JTSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define JTSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/jtsc_pkg.sv
// types and codes for the json token structure checker
// no dependencies; imported by the checker unit
package jtsc_pkg;

	localparam int KIND_W        = 4;
	localparam int DEPTH_LIMIT_W = 7;
	localparam int NEST_W        = 7;
	localparam int CTX_W         = 3;

	// lexer token kinds; codes 13 to 15 carry no meaning
	typedef enum logic [KIND_W-1:0] {
		K_OBJ_OPEN  = 4'd0,
		K_OBJ_CLOSE = 4'd1,
		K_ARR_OPEN  = 4'd2,
		K_ARR_CLOSE = 4'd3,
		K_COLON     = 4'd4,
		K_COMMA     = 4'd5,
		K_STRING    = 4'd6,
		K_NUMBER    = 4'd7,
		K_TRUE      = 4'd8,
		K_FALSE     = 4'd9,
		K_NULL      = 4'd10,
		K_EOF       = 4'd11,
		K_OTHER     = 4'd12
	} kind_t;

	// per-token result status
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DONE     = 3'd1,
		ST_UNEXP    = 3'd2,
		ST_NEEDOPEN = 3'd3,
		ST_BADNUM   = 3'd4,
		ST_DEEP     = 3'd5
	} status_t;

	// per-level context of an open container
	typedef enum logic [CTX_W-1:0] {
		C_OKEYEND   = 3'd0,
		C_OKEY      = 3'd1,
		C_OCOLON    = 3'd2,
		C_OVALUE    = 3'd3,
		C_OCOMMAEND = 3'd4,
		C_AVALEND   = 3'd5,
		C_AVALUE    = 3'd6,
		C_ACOMMAEND = 3'd7
	} ctx_t;

	// document phase
	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_INSIDE = 2'd1,
		PH_AFTER  = 2'd2
	} phase_t;

	// statuses that end the document and echo the position
	function automatic logic is_error(status_t st);
		return st inside {ST_UNEXP, ST_NEEDOPEN, ST_BADNUM, ST_DEEP};
	endfunction

endpackage

### hdl/jtsc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; used for the context stack
module jtsc_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/json_token_structure_checker_unit.sv
// Checks JSON structure on a stream of lexer tokens, one status beat per token beat.
// A token passes an input register, is checked against the document phase, the
// top-of-stack context and the entry below it, and lands in a result register:
// one token is taken every cycle while status beats drain; a waiting status beat
// stalls the input once the input register holds a token. The top context lives in a
// register and the entry below it is prefetched from the stack ram every cycle (with a
// write bypass), so pushes and pops do not stall the token stream. The stack ram
// needs no clearing after reset. Depends on jtsc_pkg, jtsc_ram and
// json_token_structure_checker_unit_defines.svh.
`include "json_token_structure_checker_unit_defines.svh"

module json_token_structure_checker_unit import jtsc_pkg::*; #(
	parameter int MAX_DEPTH = 64,
	parameter int POS_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [DEPTH_LIMIT_W-1:0] cfg_data,
	// token beats
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        token_kind,
	input  logic                     number_ok,
	input  logic [POS_WIDTH-1:0]     token_line,
	input  logic [POS_WIDTH-1:0]     token_column,
	// status beats
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               status,
	output logic [POS_WIDTH-1:0]     error_line,
	output logic [POS_WIDTH-1:0]     error_column,
	output logic [NEST_W-1:0]        nesting_depth
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int LW = $clog2(MAX_DEPTH + 1);
	localparam int CW = (LW > DEPTH_LIMIT_W) ? LW : DEPTH_LIMIT_W;

	// configuration register
	logic [DEPTH_LIMIT_W-1:0] depth_limit_q;

	// input stage
	logic                 valid_s1;
	logic [KIND_W-1:0]    token_kind_s1;
	logic                 number_ok_s1;
	logic [POS_WIDTH-1:0] token_line_s1;
	logic [POS_WIDTH-1:0] token_column_s1;

	// checker state
	phase_t        phase_q, phase_n;
	logic [LW-1:0] level_q, level_n;
	ctx_t          top_q, top_n;
	logic          byp_q;
	ctx_t          byp_data_q;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [POS_WIDTH-1:0] error_line_q;
	logic [POS_WIDTH-1:0] error_column_q;
	logic [NEST_W-1:0]    nesting_depth_q;

	// step signals
	logic          fire;
	status_t       st;
	logic          err;
	logic          push;
	logic          pop;
	logic          open_root;
	ctx_t          wr_ctx;
	ctx_t          below;
	logic [CTX_W-1:0] rd_data;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [LW-1:0] lvl_rd;
	logic [CW-1:0] lim;
	logic          at_limit;
	logic          val_ok;
	ctx_t          val_top;
	ctx_t          open_ctx;

	// handshakes
	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= DEPTH_LIMIT_W'(64);
		end else if (cfg_valid) begin
			depth_limit_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			token_kind_s1   <= token_kind;
			number_ok_s1    <= number_ok;
			token_line_s1   <= token_line;
			token_column_s1 <= token_column;
		end
	end

	// effective depth limit and entry below the top
	assign lim      = (CW'(depth_limit_q) < CW'(MAX_DEPTH)) ? CW'(depth_limit_q) : CW'(MAX_DEPTH);
	assign at_limit = CW'(level_q) >= lim;
	assign below    = byp_q ? byp_data_q : ctx_t'(rd_data);

	// scalar value placement in the top context
	assign val_ok   = (top_q == C_OVALUE) || (top_q == C_AVALEND) || (top_q == C_AVALUE);
	assign val_top  = (top_q == C_OVALUE) ? C_OCOMMAEND : C_ACOMMAEND;
	assign open_ctx = (token_kind_s1 == K_OBJ_OPEN) ? C_OKEYEND : C_AVALEND;

	// token check: status and stack action
	always_comb begin
		st        = ST_OK;
		top_n     = top_q;
		push      = 1'b0;
		pop       = 1'b0;
		open_root = 1'b0;
		wr_ctx    = val_top;
		case (phase_q)
			PH_INSIDE: begin
				if (level_q == '0) begin
					st = ST_UNEXP;
				end else begin
					case (token_kind_s1)
						K_OBJ_OPEN, K_ARR_OPEN: begin
							if (!val_ok) begin
								st = ST_UNEXP;
							end else if (at_limit) begin
								st = ST_DEEP;
							end else begin
								push  = 1'b1;
								top_n = open_ctx;
							end
						end
						K_OBJ_CLOSE: begin
							if (top_q == C_OKEYEND || top_q == C_OCOMMAEND) begin
								pop   = 1'b1;
								top_n = below;
							end else begin
								st = ST_UNEXP;
							end
						end
						K_ARR_CLOSE: begin
							if (top_q == C_AVALEND || top_q == C_ACOMMAEND) begin
								pop   = 1'b1;
								top_n = below;
							end else begin
								st = ST_UNEXP;
							end
						end
						K_COLON: begin
							if (top_q == C_OCOLON) begin
								top_n = C_OVALUE;
							end else begin
								st = ST_UNEXP;
							end
						end
						K_COMMA: begin
							if (top_q == C_OCOMMAEND) begin
								top_n = C_OKEY;
							end else if (top_q == C_ACOMMAEND) begin
								top_n = C_AVALUE;
							end else begin
								st = ST_UNEXP;
							end
						end
						K_STRING: begin
							if (top_q == C_OKEYEND || top_q == C_OKEY) begin
								top_n = C_OCOLON;
							end else if (val_ok) begin
								top_n = val_top;
							end else begin
								st = ST_UNEXP;
							end
						end
						K_NUMBER: begin
							if (!number_ok_s1) begin
								st = ST_BADNUM;
							end else if (val_ok) begin
								top_n = val_top;
							end else begin
								st = ST_UNEXP;
							end
						end
						K_TRUE, K_FALSE, K_NULL: begin
							if (val_ok) begin
								top_n = val_top;
							end else begin
								st = ST_UNEXP;
							end
						end
						default: begin
							st = ST_UNEXP;
						end
					endcase
				end
			end
			PH_AFTER: begin
				st = (token_kind_s1 == K_EOF) ? ST_DONE : ST_UNEXP;
			end
			default: begin
				if (token_kind_s1 == K_OBJ_OPEN || token_kind_s1 == K_ARR_OPEN) begin
					if (lim == '0) begin
						st = ST_DEEP;
					end else begin
						open_root = 1'b1;
						top_n     = open_ctx;
					end
				end else begin
					st = ST_NEEDOPEN;
				end
			end
		endcase
	end

	assign err = is_error(st);

	// next stack level
	always_comb begin
		if (err || st == ST_DONE) begin
			level_n = '0;
		end else if (open_root) begin
			level_n = LW'(1);
		end else if (push) begin
			level_n = LW'(level_q + LW'(1));
		end else if (pop) begin
			level_n = LW'(level_q - LW'(1));
		end else begin
			level_n = level_q;
		end
	end

	// next document phase
	always_comb begin
		phase_n = phase_q;
		if (err || st == ST_DONE) begin
			phase_n = PH_WAIT;
		end else begin
			case (phase_q)
				PH_INSIDE: begin
					if (pop && level_q == LW'(1)) begin
						phase_n = PH_AFTER;
					end
				end
				PH_AFTER: begin
					phase_n = PH_AFTER;
				end
				default: begin
					phase_n = PH_INSIDE;
				end
			endcase
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			level_q <= '0;
			top_q   <= C_OKEYEND;
		end else if (fire) begin
			phase_q <= phase_n;
			level_q <= level_n;
			top_q   <= top_n;
		end
	end

	// stack ram: on a push the top's after-value context goes down, entry below is prefetched
	assign wr_addr = AW'(level_q - LW'(1));
	assign lvl_rd  = fire ? level_n : level_q;
	assign rd_addr = AW'(lvl_rd - LW'(2));

	jtsc_ram #(
		.WIDTH(CTX_W),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (fire && push),
		.wr_addr(wr_addr),
		.wr_data(wr_ctx),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// bypass when the prefetch hits the entry being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= fire && push && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_ctx;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q        <= st;
			error_line_q    <= err ? token_line_s1 : '0;
			error_column_q  <= err ? token_column_s1 : '0;
			nesting_depth_q <= NEST_W'(level_n);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign error_line    = error_line_q;
	assign error_column  = error_column_q;
	assign nesting_depth = nesting_depth_q;

	// an error beat closes the document
	`JTSC_ASSERT(a_err_depth_zero, out_valid_q && is_error(status_q) |-> nesting_depth_q == '0, "error beat with open containers")
	// positions are echoed only on errors
	`JTSC_ASSERT(a_pos_only_on_err, out_valid_q && !is_error(status_q) |-> error_line_q == '0 && error_column_q == '0, "position on non-error beat")
	// open containers exist exactly while inside the root
	`JTSC_ASSERT(a_phase_level, (phase_q == PH_INSIDE) == (level_q != '0), "phase and level disagree")
	// level never passes the stack size
	`JTSC_ASSERT(a_level_bound, CW'(level_q) <= CW'(MAX_DEPTH), "stack level beyond stack size")
	// a completed document leaves no open containers and returns to waiting
	`JTSC_ASSERT(a_done_resets, fire && st == ST_DONE |=> phase_q == PH_WAIT && level_q == '0, "document end not cleared")

endmodule
